// ----- rtl/core/dnls_pkg.sv -----
// Shared types, constants and word tables for the DNS name label splitter.
// No dependencies.
`default_nettype none
package dnls_pkg;

  localparam int unsigned NUM_WORDS = 9;
  localparam int unsigned WORD_FR   = 0;

  localparam logic [7:0] DOT_CHAR = 8'h2E;
  localparam logic [7:0] UPPER_A  = 8'h41;
  localparam logic [7:0] UPPER_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  localparam logic [NUM_WORDS-1:0] SECTOR_MASK = 9'h1FE;
  localparam logic [NUM_WORDS-1:0] ALL_WORDS   = 9'h1FF;

  // store each word last-first so byte i sits at bits [8i+7:8i]
  localparam logic [63:0] WORD_TEXT [NUM_WORDS] = '{
    64'("rf"), 64'("mon"), 64'("moc"), 64'("esserp"), 64'("ossa"),
    64'("icc"), 64'("seriaton"), 64'("vuog"), 64'("mt")
  };

  localparam logic [3:0] WORD_LEN [NUM_WORDS] = '{
    4'd2, 4'd3, 4'd3, 4'd6, 4'd4, 4'd3, 4'd8, 4'd4, 4'd2
  };

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_TOO_LONG = 2'd2
  } status_t;

  typedef struct packed {
    logic [NUM_WORDS-1:0] match_nxt;
    logic [NUM_WORDS-1:0] exact_cur;
    logic [NUM_WORDS-1:0] exact_nxt;
  } match_info_t;

endpackage
`default_nettype wire

// ----- rtl/core/dnls_word_match.sv -----
// Per-character match of the current label against every word in the word table.
// Depends on dnls_pkg.
`default_nettype none
module dnls_word_match (
  input  wire logic [7:0]                    lower_char,
  input  wire logic [3:0]                    char_index,
  input  wire logic [dnls_pkg::NUM_WORDS-1:0] match_vec,
  output dnls_pkg::match_info_t              info
);
  import dnls_pkg::*;

  logic [3:0] index_nxt;

  assign index_nxt = (char_index < 4'd15) ? char_index + 4'd1 : char_index;

  always_comb begin
    for (int w = 0; w < NUM_WORDS; w++) begin
      info.match_nxt[w] = match_vec[w] && (char_index < WORD_LEN[w]) &&
                          (WORD_TEXT[w][{char_index[2:0], 3'b000} +: 8] == lower_char);
      info.exact_cur[w] = match_vec[w] && (char_index == WORD_LEN[w]);
      info.exact_nxt[w] = info.match_nxt[w] && (index_nxt == WORD_LEN[w]);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/domain_name_label_splitter_unit.sv -----
// A byte passes through the input register and then the result register on its way out.
// Throughput: one byte per cycle unless the result side stalls; the state update is combinational.
// Backpressure on the result side stalls the input register, which stays full.
// Reset (rst_n low, synchronous) empties both registers and returns the scan
// state to the start-of-name values; the state also returns there after each last byte.
`default_nettype none
module domain_name_label_splitter_unit #(
  parameter int unsigned MAX_NAME_LENGTH = 255
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_name_char,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_lower_char,
  output logic            out_done_res,
  output logic [1:0]      out_status,
  output logic [7:0]      out_name_length,
  output logic [7:0]      out_label_count,
  output logic [7:0]      out_tld_start,
  output logic [7:0]      out_reg_start
);
  import dnls_pkg::*;

  localparam int unsigned CW = $clog2(MAX_NAME_LENGTH + 2);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_NAME_LENGTH);

  logic                 in_vld_r;
  logic [7:0]           in_char_r;
  logic                 in_last_r;
  logic                 advance;

  logic [CW-1:0]        raw_count_r, raw_count_nxt;
  logic [7:0]           dot_count_r, dot_count_nxt;
  logic [7:0]           start0_r, start0_nxt;
  logic [7:0]           start1_r, start1_nxt;
  logic [7:0]           start2_r, start2_nxt;
  logic [3:0]           char_index_r, char_index_nxt;
  logic [NUM_WORDS-1:0] match_vec_r, match_vec_nxt;
  logic                 prev_sector_r, prev_sector_nxt;
  logic                 seen_r, seen_nxt;
  logic [7:0]           snap_len_r, snap_len_nxt;
  logic [7:0]           snap_lab_r, snap_lab_nxt;
  logic [7:0]           snap_tld_r, snap_tld_nxt;
  logic [7:0]           snap_reg_r, snap_reg_nxt;

  logic [7:0]           lc;
  logic [7:0]           pos_plus1;
  match_info_t          minfo;
  status_t              status;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !in_vld_r || advance;

  assign lc = ((in_char_r >= UPPER_A) && (in_char_r <= UPPER_Z)) ?
              in_char_r + CASE_OFS : in_char_r;
  assign pos_plus1 = 8'(raw_count_r) + 8'd1;

  dnls_word_match u_match (
    .lower_char (lc),
    .char_index (char_index_r),
    .match_vec  (match_vec_r),
    .info       (minfo)
  );

  always_comb begin
    raw_count_nxt   = (raw_count_r <= MAX_C) ? raw_count_r + CW'(1) : raw_count_r;
    dot_count_nxt   = dot_count_r;
    start0_nxt      = start0_r;
    start1_nxt      = start1_r;
    start2_nxt      = start2_r;
    char_index_nxt  = char_index_r;
    match_vec_nxt   = match_vec_r;
    prev_sector_nxt = prev_sector_r;
    seen_nxt        = seen_r;
    snap_len_nxt    = snap_len_r;
    snap_lab_nxt    = snap_lab_r;
    snap_tld_nxt    = snap_tld_r;
    snap_reg_nxt    = snap_reg_r;
    if (lc == DOT_CHAR) begin
      prev_sector_nxt = |(minfo.exact_cur & SECTOR_MASK);
      dot_count_nxt   = (dot_count_r < 8'd255) ? dot_count_r + 8'd1 : dot_count_r;
      start2_nxt      = start1_r;
      start1_nxt      = start0_r;
      start0_nxt      = pos_plus1;
      char_index_nxt  = 4'd0;
      match_vec_nxt   = ALL_WORDS;
    end else begin
      match_vec_nxt  = minfo.match_nxt;
      char_index_nxt = (char_index_r < 4'd15) ? char_index_r + 4'd1 : char_index_r;
      seen_nxt       = 1'b1;
      snap_len_nxt   = pos_plus1;
      snap_lab_nxt   = (dot_count_r == 8'd255) ? 8'd255 : dot_count_r + 8'd1;
      snap_tld_nxt   = start0_r;
      snap_reg_nxt   = (minfo.exact_nxt[WORD_FR] && prev_sector_r) ? start2_r : start1_r;
    end
    if (raw_count_nxt > MAX_C) begin
      status = STATUS_TOO_LONG;
    end else if (!seen_nxt) begin
      status = STATUS_EMPTY;
    end else begin
      status = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_char_r <= in_name_char;
      in_last_r <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_vld_r) begin
      out_lower_char  <= lc;
      out_done_res    <= in_last_r;
      out_status      <= in_last_r ? status : STATUS_OK;
      if (in_last_r && (status == STATUS_OK)) begin
        out_name_length <= snap_len_nxt;
        out_label_count <= snap_lab_nxt;
        out_tld_start   <= snap_tld_nxt;
        out_reg_start   <= snap_reg_nxt;
      end else begin
        out_name_length <= 8'd0;
        out_label_count <= 8'd0;
        out_tld_start   <= 8'd0;
        out_reg_start   <= 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (advance && in_vld_r && in_last_r)) begin
      raw_count_r   <= '0;
      dot_count_r   <= 8'd0;
      start0_r      <= 8'd0;
      start1_r      <= 8'd0;
      start2_r      <= 8'd0;
      char_index_r  <= 4'd0;
      match_vec_r   <= ALL_WORDS;
      prev_sector_r <= 1'b0;
      seen_r        <= 1'b0;
      snap_len_r    <= 8'd0;
      snap_lab_r    <= 8'd0;
      snap_tld_r    <= 8'd0;
      snap_reg_r    <= 8'd0;
    end else if (advance && in_vld_r) begin
      raw_count_r   <= raw_count_nxt;
      dot_count_r   <= dot_count_nxt;
      start0_r      <= start0_nxt;
      start1_r      <= start1_nxt;
      start2_r      <= start2_nxt;
      char_index_r  <= char_index_nxt;
      match_vec_r   <= match_vec_nxt;
      prev_sector_r <= prev_sector_nxt;
      seen_r        <= seen_nxt;
      snap_len_r    <= snap_len_nxt;
      snap_lab_r    <= snap_lab_nxt;
      snap_tld_r    <= snap_tld_nxt;
      snap_reg_r    <= snap_reg_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- bench/name_scan_checker_pkg.sv -----
// Scoreboard for the DNS name label splitter: predicts the result of every
// accepted byte and checks results in order. Depends on dnls_pkg.
package name_scan_checker_pkg;
  import dnls_pkg::*;

  localparam string SUFFIX_WORDS [NUM_WORDS] = '{
    "fr", "nom", "com", "presse", "asso", "cci", "notaires", "gouv", "tm"
  };

  typedef struct packed {
    logic [7:0] lower_char;
    logic       done_res;
    status_t    status;
    logic [7:0] name_length;
    logic [7:0] label_count;
    logic [7:0] tld_start;
    logic [7:0] reg_start;
  } scan_result_t;

  class name_scan_checker;
    int unsigned name_limit;
    int unsigned errors;
    int unsigned results_seen;
    scan_result_t expected_q[$];

    int unsigned byte_count;
    int unsigned dot_total;
    int unsigned starts [3];
    int unsigned label_idx;
    logic [NUM_WORDS-1:0] word_hits;
    logic prev_sector;
    logic seen_text;
    int unsigned snap_len;
    int unsigned snap_labels;
    int unsigned snap_tld;
    int unsigned snap_reg;

    function new(int unsigned limit);
      name_limit = limit;
      errors = 0;
      results_seen = 0;
      restart();
    endfunction

    function void restart();
      byte_count = 0;
      dot_total = 0;
      starts[0] = 0;
      starts[1] = 0;
      starts[2] = 0;
      label_idx = 0;
      word_hits = ALL_WORDS;
      prev_sector = 1'b0;
      seen_text = 1'b0;
      snap_len = 0;
      snap_labels = 0;
      snap_tld = 0;
      snap_reg = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function logic [NUM_WORDS-1:0] whole_words();
      logic [NUM_WORDS-1:0] m;
      string wd;
      m = '0;
      for (int w = 0; w < NUM_WORDS; w++) begin
        wd = SUFFIX_WORDS[w];
        m[w] = word_hits[w] && (label_idx == wd.len());
      end
      return m;
    endfunction

    function void note_byte(logic [7:0] c, logic fin);
      scan_result_t r;
      logic [7:0] lc;
      logic [NUM_WORDS-1:0] hits_now;
      int unsigned pos;
      string wd;
      lc = (c >= UPPER_A && c <= UPPER_Z) ? c + CASE_OFS : c;
      pos = byte_count;
      if (byte_count <= name_limit) byte_count++;
      if (lc == DOT_CHAR) begin
        hits_now = whole_words();
        prev_sector = |(hits_now & SECTOR_MASK);
        if (dot_total < 255) dot_total++;
        starts[2] = starts[1];
        starts[1] = starts[0];
        starts[0] = pos + 1;
        label_idx = 0;
        word_hits = ALL_WORDS;
      end else begin
        for (int w = 0; w < NUM_WORDS; w++) begin
          wd = SUFFIX_WORDS[w];
          if (label_idx >= wd.len() || wd[label_idx] != lc) word_hits[w] = 1'b0;
        end
        if (label_idx < 15) label_idx++;
        hits_now = whole_words();
        seen_text = 1'b1;
        snap_len = pos + 1;
        snap_labels = (dot_total + 1 > 255) ? 255 : dot_total + 1;
        snap_tld = starts[0];
        snap_reg = (hits_now[WORD_FR] && prev_sector) ? starts[2] : starts[1];
      end
      r = '0;
      r.lower_char = lc;
      r.done_res = fin;
      if (fin) begin
        if (byte_count > name_limit) r.status = STATUS_TOO_LONG;
        else if (!seen_text) r.status = STATUS_EMPTY;
        else r.status = STATUS_OK;
        if (r.status == STATUS_OK) begin
          r.name_length = snap_len[7:0];
          r.label_count = snap_labels[7:0];
          r.tld_start = snap_tld[7:0];
          r.reg_start = snap_reg[7:0];
        end
        restart();
      end
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at result %0d: %s", results_seen, msg);
      errors++;
    endtask

    task compare_field(string field, int unsigned got, int unsigned want);
      if (got != want)
        report_mismatch($sformatf("%s got %0d expected %0d", field, got, want));
    endtask

    task check_byte(scan_result_t got);
      scan_result_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("result with no byte outstanding");
        return;
      end
      want = expected_q.pop_front();
      compare_field("lower_char", got.lower_char, want.lower_char);
      compare_field("done_res", got.done_res, want.done_res);
      compare_field("status", got.status, want.status);
      compare_field("name_length", got.name_length, want.name_length);
      compare_field("label_count", got.label_count, want.label_count);
      compare_field("tld_start", got.tld_start, want.tld_start);
      compare_field("reg_start", got.reg_start, want.reg_start);
    endtask
  endclass

endpackage

// ----- bench/testbench.sv -----
// Top-level bench for domain_name_label_splitter_unit: drives directed and
// random DNS names byte by byte under varying idle and stall phases.
// Depends on dnls_pkg and name_scan_checker_pkg.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dnls_pkg::*;
  import name_scan_checker_pkg::*;

  localparam int unsigned NAME_LIMIT = 255;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned RANDOM_BYTES_PER_PHASE = 170;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_name_char = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_lower_char;
  logic       out_done_res;
  logic [1:0] out_status;
  logic [7:0] out_name_length;
  logic [7:0] out_label_count;
  logic [7:0] out_tld_start;
  logic [7:0] out_reg_start;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned quiet_cycles = 0;
  int unsigned bytes_sent = 0;
  name_scan_checker sb;
  scan_result_t seen_result;

  domain_name_label_splitter_unit #(
    .MAX_NAME_LENGTH(NAME_LIMIT)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_name_char(in_name_char),
    .in_last(in_last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_lower_char(out_lower_char),
    .out_done_res(out_done_res),
    .out_status(out_status),
    .out_name_length(out_name_length),
    .out_label_count(out_label_count),
    .out_tld_start(out_tld_start),
    .out_reg_start(out_reg_start)
  );

  always #10 clk = ~clk;

  assign seen_result = '{
    lower_char: out_lower_char,
    done_res: out_done_res,
    status: status_t'(out_status),
    name_length: out_name_length,
    label_count: out_label_count,
    tld_start: out_tld_start,
    reg_start: out_reg_start
  };

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_byte(in_name_char, in_last);
    if (rst_n && out_valid && out_ready) sb.check_byte(seen_result);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("testbench: errors");
    $finish;
  end

  function automatic logic [7:0] mixed_case(logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7A && $urandom_range(1) == 1) return c - 8'h20;
    return c;
  endfunction

  function automatic logic [7:0] rand_letter();
    return mixed_case(8'h61 + 8'($urandom_range(25)));
  endfunction

  function automatic void push_word(ref logic [7:0] q[$], input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(mixed_case(s[i]));
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic fin);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_name_char <= c;
    in_last <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_bytes(input logic [7:0] q[$]);
    for (int i = 0; i < q.size(); i++) send_byte(q[i], i == q.size() - 1);
    bytes_sent += q.size();
  endtask

  task automatic send_text(input string s);
    logic [7:0] q[$];
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    send_bytes(q);
  endtask

  task automatic send_long_name(input int unsigned len);
    logic [7:0] q[$];
    for (int i = 0; i < len; i++)
      q.push_back(($urandom_range(7) == 0 && i + 1 < len) ? DOT_CHAR : rand_letter());
    send_bytes(q);
  endtask

  task automatic send_random_name();
    logic [7:0] q[$];
    int unsigned kind;
    int unsigned labels;
    int unsigned sel;
    kind = $urandom_range(99);
    if (kind < 6) begin
      repeat ($urandom_range(4, 1)) q.push_back(DOT_CHAR);
    end else if (kind < 10) begin
      repeat ($urandom_range(12, 1)) q.push_back(8'($urandom_range(255)));
    end else begin
      labels = $urandom_range(4, 1);
      for (int i = 0; i < labels; i++) begin
        if (i > 0) q.push_back(DOT_CHAR);
        sel = $urandom_range(99);
        if (i == labels - 1 && sel < 50) begin
          push_word(q, "fr");
        end else if (sel < 30) begin
          push_word(q, SUFFIX_WORDS[$urandom_range(NUM_WORDS - 1)]);
        end else if (sel < 38) begin
          push_word(q, SUFFIX_WORDS[$urandom_range(NUM_WORDS - 1)]);
          q.push_back(rand_letter());
        end else if (sel < 75) begin
          repeat ($urandom_range(20, 1)) q.push_back(rand_letter());
        end else if (sel < 92) begin
          repeat ($urandom_range(6, 1)) q.push_back(8'($urandom_range(255)));
        end
      end
      if ($urandom_range(4) == 0) repeat ($urandom_range(2, 1)) q.push_back(DOT_CHAR);
    end
    if (q.size() == 0) q.push_back(DOT_CHAR);
    send_bytes(q);
  endtask

  initial begin
    int unsigned target;
    sb = new(NAME_LIMIT);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_text("z.Gouv.FR.");
    send_text("..");
    send_bytes('{8'h00, 8'h40, 8'h41, 8'h5A, 8'h5B, 8'hFF});
    send_text("Tm.fr");
    send_text("a..fr");

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
          send_long_name(NAME_LIMIT);
        end
        1: begin
          idle_pct = 47;
          stall_pct = 0;
          send_long_name(NAME_LIMIT + 1);
        end
        2: begin
          idle_pct = 0;
          stall_pct = 47;
          send_long_name($urandom_range(NAME_LIMIT + 45, NAME_LIMIT + 2));
        end
        default: begin
          idle_pct = 35;
          stall_pct = 35;
        end
      endcase
      target = bytes_sent + RANDOM_BYTES_PER_PHASE;
      while (bytes_sent < target) send_random_name();
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule
